### rtl/modbus_tcp_request_server_unit_defines.svh
// Assertion macros shared by the Modbus TCP request server RTL
`ifndef MODBUS_TCP_REQUEST_SERVER_UNIT_DEFINES_SVH
`define MODBUS_TCP_REQUEST_SERVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MBTCP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MBTCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mbtcp_pkg.sv
// Shared types and constants for the Modbus TCP request server
`default_nettype none
package mbtcp_pkg;

    localparam int DEF_COIL_COUNT      = 2048;
    localparam int DEF_HOLDING_COUNT   = 1024;
    localparam int DEF_INPUT_REG_COUNT = 1024;
    localparam int DEF_FRAME_CAPACITY  = 512;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_COIL  = 2'd1;
    localparam logic [1:0] MODE_INPUT = 2'd2;

    localparam logic [7:0] FC_READ_COILS  = 8'h01;
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_READ_INPUT  = 8'h04;
    localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

    localparam logic [7:0] EXC_FLAG    = 8'h80;
    localparam logic [7:0] EXC_FUNC    = 8'h01;
    localparam logic [7:0] EXC_ADDR    = 8'h02;
    localparam logic [7:0] EXC_VALUE   = 8'h03;
    localparam logic [15:0] PROTO_ID   = 16'h0000;

    localparam int MAX_COIL_QTY  = 2000;
    localparam int MAX_READ_QTY  = 125;
    localparam int MAX_WRITE_QTY = 123;
    localparam int MIN_FRAME     = 8;
    localparam int HDR_BYTES     = 13;
    localparam int WORD_BYTES    = 8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  byte_value;
        logic        frame_end;
        logic [15:0] load_index;
        logic [15:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic [63:0] resp_word;
        logic [3:0]  resp_bytes;
        logic        resp_last;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_push;

    typedef struct packed {
        logic        coil_we;
        logic        inp_we;
        logic [15:0] load_idx;
        logic [15:0] load_val;
        logic        hold_we;
        logic [15:0] hold_wa;
        logic [15:0] hold_wd;
        logic [15:0] rd_idx;
    } t_store_req;

    typedef struct packed {
        logic        clearing;
        logic        coil_rd;
        logic [15:0] hold_rd;
        logic [15:0] inp_rd;
    } t_store_rsp;

endpackage
`default_nettype wire

### rtl/mbtcp_store.sv
// Coil, holding-register and input-register memories with post-reset clear
`default_nettype none
module mbtcp_store #(
    parameter int COIL_COUNT      = mbtcp_pkg::DEF_COIL_COUNT,
    parameter int HOLDING_COUNT   = mbtcp_pkg::DEF_HOLDING_COUNT,
    parameter int INPUT_REG_COUNT = mbtcp_pkg::DEF_INPUT_REG_COUNT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mbtcp_pkg::t_store_req  i_req,
    output mbtcp_pkg::t_store_rsp       o_rsp
);
    import mbtcp_pkg::*;

    localparam int MAXC0 = (COIL_COUNT > HOLDING_COUNT) ? COIL_COUNT : HOLDING_COUNT;
    localparam int MAXC  = (MAXC0 > INPUT_REG_COUNT) ? MAXC0 : INPUT_REG_COUNT;
    localparam int CLW   = (MAXC > 1) ? $clog2(MAXC) : 1;
    localparam int CW    = $clog2(COIL_COUNT);
    localparam int HW    = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int IW    = (INPUT_REG_COUNT > 1) ? $clog2(INPUT_REG_COUNT) : 1;

    logic              r_clearing;
    logic [CLW-1:0]    r_clr_idx;

    logic              r_coil [COIL_COUNT];
    logic [15:0]       r_hold [HOLDING_COUNT];
    logic [15:0]       r_inp  [INPUT_REG_COUNT];
    logic              r_coil_rd;
    logic [15:0]       r_hold_rd;
    logic [15:0]       r_inp_rd;

    logic              coil_we;
    logic [CW-1:0]     coil_wa;
    logic              coil_wd;
    logic              hold_we;
    logic [HW-1:0]     hold_wa;
    logic [15:0]       hold_wd;
    logic              inp_we;
    logic [IW-1:0]     inp_wa;
    logic [15:0]       inp_wd;

    // one entry of every store per cycle until the largest one is swept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + CLW'(1);
            if (32'(r_clr_idx) == 32'(MAXC - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clearing) begin
            coil_we = 32'(r_clr_idx) < 32'(COIL_COUNT);
            coil_wa = r_clr_idx[CW-1:0];
            coil_wd = 1'b0;
            hold_we = 32'(r_clr_idx) < 32'(HOLDING_COUNT);
            hold_wa = r_clr_idx[HW-1:0];
            hold_wd = '0;
            inp_we  = 32'(r_clr_idx) < 32'(INPUT_REG_COUNT);
            inp_wa  = r_clr_idx[IW-1:0];
            inp_wd  = '0;
        end else begin
            coil_we = i_req.coil_we;
            coil_wa = i_req.load_idx[CW-1:0];
            coil_wd = i_req.load_val[0];
            hold_we = i_req.hold_we;
            hold_wa = i_req.hold_wa[HW-1:0];
            hold_wd = i_req.hold_wd;
            inp_we  = i_req.inp_we;
            inp_wa  = i_req.load_idx[IW-1:0];
            inp_wd  = i_req.load_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (coil_we) begin
            r_coil[coil_wa] <= coil_wd;
        end
        r_coil_rd <= r_coil[i_req.rd_idx[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            r_hold[hold_wa] <= hold_wd;
        end
        r_hold_rd <= r_hold[i_req.rd_idx[HW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (inp_we) begin
            r_inp[inp_wa] <= inp_wd;
        end
        r_inp_rd <= r_inp[i_req.rd_idx[IW-1:0]];
    end

    assign o_rsp.clearing = r_clearing;
    assign o_rsp.coil_rd  = r_coil_rd;
    assign o_rsp.hold_rd  = r_hold_rd;
    assign o_rsp.inp_rd   = r_inp_rd;

endmodule
`default_nettype wire

### rtl/mbtcp_pack.sv
// Packs response bytes into 8-byte words behind an output register
`default_nettype none
`include "modbus_tcp_request_server_unit_defines.svh"
module mbtcp_pack (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mbtcp_pkg::t_push      i_push,
    output logic                       o_free,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output mbtcp_pkg::t_out_item       o_out_item
);
    import mbtcp_pkg::*;

    logic [63:0]    r_acc;
    logic [2:0]     r_cnt;
    logic           r_ovalid;
    t_out_item      r_oitem;

    logic [63:0]    n_acc;
    logic [2:0]     lane;
    logic           emit;

    assign lane = 3'(3'd7 - r_cnt);
    assign emit = i_push.valid && ((32'(r_cnt) == WORD_BYTES - 1) || i_push.last);
    assign o_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_acc = r_acc;
        n_acc[{lane, 3'b000} +: 8] = i_push.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_push.valid) begin
                if (emit) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= r_cnt + 3'd1;
                end
            end
            if (emit) begin
                r_ovalid             <= 1'b1;
                r_oitem.resp_word    <= n_acc;
                r_oitem.resp_bytes   <= {1'b0, r_cnt} + 4'd1;
                r_oitem.resp_last    <= i_push.last;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_oitem;

    `MBTCP_ASSERT_NOW(a_push_gated, i_clk, i_rst_n, i_push.valid, o_free, "byte pushed while word slot busy")
    `MBTCP_ASSERT_NEXT(a_last_flush, i_clk, i_rst_n, i_push.valid && i_push.last, r_cnt == 3'd0, "partial word left after last byte")
    `MBTCP_ASSERT_NOW(a_bytes_range, i_clk, i_rst_n, r_ovalid, r_oitem.resp_bytes != 4'd0 && r_oitem.resp_bytes <= 4'd8, "bad byte count")

endmodule
`default_nettype wire

### rtl/mbtcp_seq.sv
// Request buffer and sequencer: frame capture, decode, store access, response bytes
`default_nettype none
`include "modbus_tcp_request_server_unit_defines.svh"
module mbtcp_seq #(
    parameter int COIL_COUNT      = mbtcp_pkg::DEF_COIL_COUNT,
    parameter int HOLDING_COUNT   = mbtcp_pkg::DEF_HOLDING_COUNT,
    parameter int INPUT_REG_COUNT = mbtcp_pkg::DEF_INPUT_REG_COUNT,
    parameter int FRAME_CAPACITY  = mbtcp_pkg::DEF_FRAME_CAPACITY
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire mbtcp_pkg::t_in_item    i_in_item,
    output mbtcp_pkg::t_store_req       o_req,
    input  wire mbtcp_pkg::t_store_rsp  i_rsp,
    output mbtcp_pkg::t_push            o_push,
    input  wire logic                   i_push_free
);
    import mbtcp_pkg::*;

    localparam int AW = $clog2(FRAME_CAPACITY);
    localparam int LW = $clog2(FRAME_CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_HDR  = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_W6   = 8'b0000_1000,
        S_MW   = 8'b0001_0000,
        S_HEAD = 8'b0010_0000,
        S_REG  = 8'b0100_0000,
        S_COIL = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {K_EXC, K_COIL, K_REG, K_ECHO} t_kind;

    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_NEXT = 2'd2;

    t_state         r_state;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  r_flen;
    logic [3:0]     r_pos;
    logic [103:0]   r_hdr;
    t_kind          r_kind;
    logic [7:0]     r_fc_out;
    logic [7:0]     r_b8;
    logic [8:0]     r_total;
    logic [8:0]     r_bi;
    logic [15:0]    r_ridx;
    logic [10:0]    r_cnt;
    logic [1:0]     r_phase;
    logic [2:0]     r_bit;
    logic [7:0]     r_cbyte;
    logic [8:0]     r_rdn;
    logic [8:0]     r_rdlim;
    logic           r_pend;
    logic           r_odd;
    logic [7:0]     r_hi;

    logic [7:0]     r_fbuf [FRAME_CAPACITY];
    logic [7:0]     r_fb_rd;
    logic [AW-1:0]  fb_ra;
    logic           fb_we;

    logic           in_acc;
    logic [LW-1:0]  len_inc;

    logic [15:0]    h_proto;
    logic [7:0]     h_unit;
    logic [7:0]     h_fc;
    logic [15:0]    h_addr;
    logic [15:0]    h_qty;
    logic [7:0]     h_bc;
    logic [LW-1:0]  plen;
    logic [16:0]    span;
    logic [7:0]     coil_bc;
    logic           qty_zero;

    t_kind          c_kind;
    t_state         c_next;
    logic [7:0]     c_fc_out;
    logic [7:0]     c_b8;
    logic [8:0]     c_total;
    logic [7:0]     c_code;

    logic [7:0]     hdr_byte;
    logic [8:0]     hdr_last;
    logic [15:0]    reg_rd;

    assign o_in_stall = (r_state != S_IDLE) || i_rsp.clearing;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign len_inc    = (r_len < LW'(FRAME_CAPACITY)) ? r_len + LW'(1) : r_len;
    assign fb_we      = in_acc && (i_in_item.mode == MODE_BYTE) && (r_len < LW'(FRAME_CAPACITY));
    assign fb_ra      = (r_state == S_MW) ? AW'(HDR_BYTES) + AW'(r_rdn) : AW'(r_pos);

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            r_fbuf[r_len[AW-1:0]] <= i_in_item.byte_value;
        end
        r_fb_rd <= r_fbuf[fb_ra];
    end

    // header bytes 0..12, byte 0 at the top
    assign h_proto = r_hdr[87:72];
    assign h_unit  = r_hdr[55:48];
    assign h_fc    = r_hdr[47:40];
    assign h_addr  = r_hdr[39:24];
    assign h_qty   = r_hdr[23:8];
    assign h_bc    = r_hdr[7:0];

    assign plen     = r_flen - LW'(7);
    assign span     = {1'b0, h_addr} + {1'b0, h_qty};
    assign qty_zero = (h_qty == 16'd0);
    assign coil_bc  = 8'((h_qty[10:0] + 11'd7) >> 3);

    always_comb begin
        c_kind   = K_EXC;
        c_next   = S_HEAD;
        c_code   = EXC_FUNC;
        c_b8     = '0;
        c_total  = 9'd9;
        unique case (h_fc)
            FC_READ_COILS: begin
                priority if (plen < LW'(5) || qty_zero || h_qty > 16'(MAX_COIL_QTY)) begin
                    c_code = EXC_VALUE;
                end else if (32'(span) > 32'(COIL_COUNT)) begin
                    c_code = EXC_ADDR;
                end else begin
                    c_kind = K_COIL;
                end
            end
            FC_READ_HOLD, FC_READ_INPUT: begin
                priority if (plen < LW'(5) || qty_zero || h_qty > 16'(MAX_READ_QTY)) begin
                    c_code = EXC_VALUE;
                end else if (32'(span) > ((h_fc == FC_READ_HOLD) ?
                             32'(HOLDING_COUNT) : 32'(INPUT_REG_COUNT))) begin
                    c_code = EXC_ADDR;
                end else begin
                    c_kind = K_REG;
                end
            end
            FC_WRITE_ONE: begin
                priority if (plen < LW'(5)) begin
                    c_code = EXC_VALUE;
                end else if (32'(h_addr) >= 32'(HOLDING_COUNT)) begin
                    c_code = EXC_ADDR;
                end else begin
                    c_kind = K_ECHO;
                    c_next = S_W6;
                end
            end
            FC_WRITE_MULTI: begin
                priority if (plen < LW'(7) || qty_zero || h_qty > 16'(MAX_WRITE_QTY) ||
                             {9'd0, h_bc} != {h_qty, 1'b0} ||
                             32'(plen) < 32'(h_bc) + 32'd6) begin
                    c_code = EXC_VALUE;
                end else if (32'(span) > 32'(HOLDING_COUNT)) begin
                    c_code = EXC_ADDR;
                end else begin
                    c_kind = K_ECHO;
                    c_next = S_MW;
                end
            end
            default: c_code = EXC_FUNC;
        endcase
        if (h_proto != PROTO_ID) begin
            c_next = S_IDLE;
        end
        unique case (c_kind)
            K_EXC:  begin c_b8 = c_code;                  c_total = 9'd9; end
            K_COIL: begin c_b8 = coil_bc;                 c_total = 9'd9 + 9'(coil_bc); end
            K_REG:  begin c_b8 = {h_qty[6:0], 1'b0};      c_total = 9'd9 + {h_qty[7:0], 1'b0}; end
            K_ECHO: begin c_b8 = r_hdr[39:32];            c_total = 9'd12; end
            default: begin c_b8 = c_code;                 c_total = 9'd9; end
        endcase
        c_fc_out = (c_kind == K_EXC) ? (h_fc | EXC_FLAG) : h_fc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.mode == MODE_BYTE) begin
                        if (i_in_item.frame_end) begin
                            r_len  <= '0;
                            r_flen <= len_inc;
                            r_pos  <= '0;
                            if (32'(len_inc) >= MIN_FRAME) begin
                                r_state <= S_HDR;
                            end
                        end else begin
                            r_len <= len_inc;
                        end
                    end
                end
                S_HDR: begin
                    // read data is registered and arrives in the cycle after its address
                    r_pos <= r_pos + 4'd1;
                    if (r_pos != 4'd0) begin
                        r_hdr <= {r_hdr[95:0], r_fb_rd};
                    end
                    if (r_pos == 4'(HDR_BYTES)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_kind   <= c_kind;
                    r_fc_out <= c_fc_out;
                    r_b8     <= c_b8;
                    r_total  <= c_total;
                    r_bi     <= '0;
                    r_ridx   <= h_addr;
                    r_cnt    <= h_qty[10:0];
                    r_phase  <= PH_ADDR;
                    r_bit    <= '0;
                    r_cbyte  <= '0;
                    r_rdn    <= '0;
                    r_rdlim  <= {h_qty[7:0], 1'b0};
                    r_pend   <= 1'b0;
                    r_odd    <= 1'b0;
                    r_state  <= c_next;
                end
                S_W6: r_state <= S_HEAD;
                S_MW: begin
                    if (r_rdn != r_rdlim) begin
                        r_rdn  <= r_rdn + 9'd1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        if (!r_odd) begin
                            r_hi  <= r_fb_rd;
                            r_odd <= 1'b1;
                        end else begin
                            r_odd  <= 1'b0;
                            r_ridx <= r_ridx + 16'd1;
                            r_cnt  <= r_cnt - 11'd1;
                            if (r_cnt == 11'd1) begin
                                r_state <= S_HEAD;
                            end
                        end
                    end
                end
                S_HEAD: begin
                    if (i_push_free) begin
                        r_bi <= r_bi + 9'd1;
                        if (r_bi == hdr_last) begin
                            priority if (r_kind == K_COIL) begin
                                r_state <= S_COIL;
                            end else if (r_kind == K_REG) begin
                                r_state <= S_REG;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_REG: begin
                    unique case (r_phase)
                        PH_ADDR: r_phase <= PH_DATA;
                        PH_DATA: begin
                            if (i_push_free) begin
                                r_bi    <= r_bi + 9'd1;
                                r_phase <= PH_NEXT;
                            end
                        end
                        PH_NEXT: begin
                            if (i_push_free) begin
                                r_bi    <= r_bi + 9'd1;
                                r_ridx  <= r_ridx + 16'd1;
                                r_cnt   <= r_cnt - 11'd1;
                                r_phase <= PH_ADDR;
                                if (r_cnt == 11'd1) begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                        default: r_phase <= PH_ADDR;
                    endcase
                end
                S_COIL: begin
                    unique case (r_phase)
                        PH_ADDR: r_phase <= PH_DATA;
                        PH_DATA: begin
                            r_cbyte[r_bit] <= i_rsp.coil_rd;
                            r_ridx         <= r_ridx + 16'd1;
                            r_cnt          <= r_cnt - 11'd1;
                            if (r_bit == 3'd7 || r_cnt == 11'd1) begin
                                r_phase <= PH_NEXT;
                            end else begin
                                r_bit   <= r_bit + 3'd1;
                                r_phase <= PH_ADDR;
                            end
                        end
                        PH_NEXT: begin
                            if (i_push_free) begin
                                r_bi    <= r_bi + 9'd1;
                                r_cbyte <= '0;
                                r_bit   <= '0;
                                r_phase <= PH_ADDR;
                                if (r_cnt == 11'd0) begin
                                    r_state <= S_IDLE;
                                end
                            end
                        end
                        default: r_phase <= PH_ADDR;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign hdr_last = (r_kind == K_ECHO) ? 9'd11 : 9'd8;
    assign reg_rd   = (r_fc_out == FC_READ_HOLD) ? i_rsp.hold_rd : i_rsp.inp_rd;

    always_comb begin
        unique case (r_bi[3:0])
            4'd0:    hdr_byte = r_hdr[103:96];
            4'd1:    hdr_byte = r_hdr[95:88];
            4'd5:    hdr_byte = 8'(r_total - 9'd6);
            4'd6:    hdr_byte = h_unit;
            4'd7:    hdr_byte = r_fc_out;
            4'd8:    hdr_byte = r_b8;
            4'd9:    hdr_byte = r_hdr[31:24];
            4'd10:   hdr_byte = r_hdr[23:16];
            4'd11:   hdr_byte = r_hdr[15:8];
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        o_push.valid = 1'b0;
        o_push.data  = hdr_byte;
        o_push.last  = (r_bi == r_total - 9'd1);
        unique case (r_state)
            S_HEAD: o_push.valid = i_push_free;
            S_REG: begin
                o_push.valid = i_push_free && (r_phase == PH_DATA || r_phase == PH_NEXT);
                o_push.data  = (r_phase == PH_DATA) ? reg_rd[15:8] : reg_rd[7:0];
            end
            S_COIL: begin
                o_push.valid = i_push_free && (r_phase == PH_NEXT);
                o_push.data  = r_cbyte;
            end
            default: o_push.valid = 1'b0;
        endcase
    end

    always_comb begin
        o_req.coil_we  = in_acc && (i_in_item.mode == MODE_COIL) &&
                         (32'(i_in_item.load_index) < 32'(COIL_COUNT));
        o_req.inp_we   = in_acc && (i_in_item.mode == MODE_INPUT) &&
                         (32'(i_in_item.load_index) < 32'(INPUT_REG_COUNT));
        o_req.load_idx = i_in_item.load_index;
        o_req.load_val = i_in_item.load_value;
        o_req.hold_we  = (r_state == S_W6) || ((r_state == S_MW) && r_pend && r_odd);
        o_req.hold_wa  = r_ridx;
        o_req.hold_wd  = (r_state == S_W6) ? h_qty : {r_hi, r_fb_rd};
        o_req.rd_idx   = r_ridx;
    end

    `MBTCP_ASSERT_NOW(a_reg_cnt, i_clk, i_rst_n, r_state == S_REG, r_cnt != 11'd0, "register read with empty count")
    `MBTCP_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_push.valid && o_push.last, r_state == S_IDLE, "sequencer busy after last byte")
    `MBTCP_ASSERT_NOW(a_no_write_clear, i_clk, i_rst_n, o_req.hold_we, !i_rsp.clearing, "holding write during clear")

endmodule
`default_nettype wire

### rtl/modbus_tcp_request_server_unit.sv
// Modbus TCP request server top level
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
// Load items and non-final request bytes are accepted one per cycle while o_in_stall is low.
// After a frame end the header is fetched from the frame buffer and decoded; for
// multiple writes the data is then read through the frame buffer port into the
// holding store, and the response header bytes, register bytes or coil bytes follow.
// After reset the stores clear one entry per cycle until the largest of COIL_COUNT,
// HOLDING_COUNT and INPUT_REG_COUNT is swept, with o_in_stall held high.
// A stalled output word holds byte production; the input stays stalled meanwhile.
`default_nettype none
module modbus_tcp_request_server_unit #(
    parameter int COIL_COUNT      = mbtcp_pkg::DEF_COIL_COUNT,
    parameter int HOLDING_COUNT   = mbtcp_pkg::DEF_HOLDING_COUNT,
    parameter int INPUT_REG_COUNT = mbtcp_pkg::DEF_INPUT_REG_COUNT,
    parameter int FRAME_CAPACITY  = mbtcp_pkg::DEF_FRAME_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire mbtcp_pkg::t_in_item   i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output mbtcp_pkg::t_out_item       o_out_item
);
    import mbtcp_pkg::*;

    t_store_req  store_req;
    t_store_rsp  store_rsp;
    t_push       push;
    logic        push_free;

    mbtcp_seq #(
        .COIL_COUNT      (COIL_COUNT),
        .HOLDING_COUNT   (HOLDING_COUNT),
        .INPUT_REG_COUNT (INPUT_REG_COUNT),
        .FRAME_CAPACITY  (FRAME_CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_req       (store_req),
        .i_rsp       (store_rsp),
        .o_push      (push),
        .i_push_free (push_free)
    );

    mbtcp_store #(
        .COIL_COUNT      (COIL_COUNT),
        .HOLDING_COUNT   (HOLDING_COUNT),
        .INPUT_REG_COUNT (INPUT_REG_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    mbtcp_pack u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_free      (push_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

### dv/tb_modbus_tcp_request_server_unit.sv
// Self-checking testbench for the Modbus TCP request server unit
`timescale 1ns / 1ps
`default_nettype none
module tb_modbus_tcp_request_server_unit;
    import mbtcp_pkg::*;

    localparam int NCOIL = DEF_COIL_COUNT;
    localparam int NHOLD = DEF_HOLDING_COUNT;
    localparam int NINP  = DEF_INPUT_REG_COUNT;
    localparam int FCAP  = DEF_FRAME_CAPACITY;
    localparam int RSP_CAP = 264;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic [7:0] FC_UNKNOWN = 8'h2B;

    typedef enum int {
        RQ_READ, RQ_WR1, RQ_WRN, RQ_WRN_BADBC, RQ_WRN_SHORT, RQ_SHORT_FRAME,
        RQ_PROTO, RQ_SHORT_PDU, RQ_OVERFLOW, RQ_LOAD_COIL, RQ_LOAD_INP, RQ_MODE3
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic [7:0]  fc;
        int          addr;
        int          qty;
        bit          typed;      // exception response typed in below
        logic [7:0]  typed_code;
    } t_dir_row;

    typedef struct {
        bit         typed;
        logic [7:0] fc;
        logic [7:0] code;
    } t_frame_tag;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;

    modbus_tcp_request_server_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow stores
    logic [7:0]  fbuf [FCAP];
    int          flen;
    bit          coil_bits [NCOIL];
    logic [15:0] hold_words [NHOLD];
    logic [15:0] inp_words [NINP];

    t_in_item   request_q [$];
    t_frame_tag tag_q [$];
    t_out_item  resp_words_q [$];

    int src_idle = 0, snk_idle = 0, hold_left = 0;
    int n_errors = 0, n_frames = 0, n_words = 0, n_exc = 0, n_dropped = 0;
    int n_queued = 0;

    function automatic int fb(int pos);
        return pos < FCAP ? int'(fbuf[pos]) : 0;
    endfunction

    function automatic int fb16(int pos);
        return (fb(pos) << 8) | fb(pos + 1);
    endfunction

    // decode a finished frame into response words
    function automatic void serve_frame(int len, t_frame_tag tag);
        logic [7:0] rb [RSP_CAP];
        int rn, plen, fc, addr, qty, bc, code, pdu_len, nw;
        t_out_item w;
        if (len < MIN_FRAME || fb16(2) != int'(PROTO_ID)) begin
            n_dropped++;
            return;
        end
        plen = len - 7;
        fc = fb(7);
        addr = fb16(8);
        qty = fb16(10);
        code = 0;
        foreach (rb[i]) rb[i] = '0;
        rb[0] = fbuf[0];
        rb[1] = fbuf[1];
        rb[6] = fbuf[6];
        rb[7] = fc[7:0];
        rn = 8;
        if (fc == FC_READ_COILS) begin
            if (plen < 5 || qty == 0 || qty > MAX_COIL_QTY) code = EXC_VALUE;
            else if (addr + qty > NCOIL) code = EXC_ADDR;
            else begin
                bc = (qty + 7) / 8;
                rb[8] = bc[7:0];
                rn = 9 + bc;
                for (int i = 0; i < qty; i++)
                    if (coil_bits[addr + i]) rb[9 + i / 8][i % 8] = 1'b1;
            end
        end else if (fc == FC_READ_HOLD || fc == FC_READ_INPUT) begin
            if (plen < 5 || qty == 0 || qty > MAX_READ_QTY) code = EXC_VALUE;
            else if (addr + qty > (fc == FC_READ_HOLD ? NHOLD : NINP)) code = EXC_ADDR;
            else begin
                rb[8] = 8'(qty * 2);
                rn = 9;
                for (int i = 0; i < qty; i++) begin
                    logic [15:0] v;
                    v = (fc == FC_READ_HOLD) ? hold_words[addr + i] : inp_words[addr + i];
                    rb[rn] = v[15:8];
                    rb[rn + 1] = v[7:0];
                    rn += 2;
                end
            end
        end else if (fc == FC_WRITE_ONE) begin
            if (plen < 5) code = EXC_VALUE;
            else if (addr >= NHOLD) code = EXC_ADDR;
            else hold_words[addr] = 16'(qty);
        end else if (fc == FC_WRITE_MULTI) begin
            bc = fb(12);
            if (plen < 7 || qty == 0 || qty > MAX_WRITE_QTY || bc != qty * 2 || plen < 6 + bc)
                code = EXC_VALUE;
            else if (addr + qty > NHOLD) code = EXC_ADDR;
            else
                for (int i = 0; i < qty; i++) hold_words[addr + i] = 16'(fb16(13 + 2 * i));
        end else begin
            code = EXC_FUNC;
        end
        if (code != 0) begin
            rb[7] = fc[7:0] | EXC_FLAG;
            rb[8] = code[7:0];
            rn = 9;
            n_exc++;
        end else if (fc == FC_WRITE_ONE || fc == FC_WRITE_MULTI) begin
            for (int i = 0; i < 4; i++) rb[8 + i] = fbuf[8 + i];
            rn = 12;
        end
        pdu_len = rn - 6;
        rb[4] = 8'(pdu_len >> 8);
        rb[5] = 8'(pdu_len);
        if (tag.typed && (rb[7] != (tag.fc | EXC_FLAG) || rb[8] != tag.code || rn != 9)) begin
            n_errors++;
            if (n_errors <= 10)
                $display("typed exception mismatch: exp fc %h code %h, predicted %h %h",
                         tag.fc | EXC_FLAG, tag.code, rb[7], rb[8]);
        end
        n_frames++;
        nw = (rn + 7) / 8;
        for (int k = 0; k < nw; k++) begin
            int n;
            n = rn - 8 * k;
            if (n > 8) n = 8;
            w.resp_word = '0;
            for (int p = 0; p < 8; p++)
                w.resp_word = {w.resp_word[55:0], (p < n) ? rb[8 * k + p] : 8'h00};
            w.resp_bytes = 4'(n);
            w.resp_last = (k + 1 == nw);
            resp_words_q = {resp_words_q, w};
        end
    endfunction

    // input side: predict on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            case (in_item.mode)
                MODE_COIL:
                    if (in_item.load_index < NCOIL) coil_bits[in_item.load_index] = in_item.load_value[0];
                MODE_INPUT:
                    if (in_item.load_index < NINP) inp_words[in_item.load_index] = in_item.load_value;
                MODE_BYTE: begin
                    if (flen < FCAP) begin
                        fbuf[flen] = in_item.byte_value;
                        flen++;
                    end
                    if (in_item.frame_end) begin
                        int len;
                        len = flen;
                        flen = 0;
                        serve_frame(len, tag_q.pop_front());
                    end
                end
                default: ;
            endcase
        end
    end

    // output side: compare against oldest expected word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_words++;
            if (resp_words_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected word %h", o_out_item.resp_word);
            end else begin
                t_out_item e;
                e = resp_words_q.pop_front();
                if (o_out_item !== e) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("word mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 e.resp_word, e.resp_bytes, e.resp_last,
                                 o_out_item.resp_word, o_out_item.resp_bytes,
                                 o_out_item.resp_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (request_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                in_item <= request_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < snk_idle);
        end
    end

    function automatic void push_item(logic [1:0] mode, logic [7:0] b, logic last,
                                      logic [15:0] idx, logic [15:0] val);
        t_in_item it;
        it.mode = mode;
        it.byte_value = b;
        it.frame_end = last;
        it.load_index = idx;
        it.load_value = val;
        request_q = {request_q, it};
        n_queued++;
    endfunction

    function automatic void push_frame(logic [7:0] bytes [$], t_frame_tag tag);
        foreach (bytes[i])
            push_item(MODE_BYTE, bytes[i], i == bytes.size() - 1,
                      16'($urandom), 16'($urandom));
        tag_q = {tag_q, tag};
    endfunction

    function automatic void queue_request(t_req_kind kind, logic [7:0] fc, int addr, int qty,
                                          t_frame_tag tag);
        logic [7:0] f [$];
        logic [15:0] proto;
        int n;
        case (kind)
            RQ_LOAD_COIL: begin
                push_item(MODE_COIL, 8'($urandom), 1'($urandom), 16'(addr), 16'(qty));
                return;
            end
            RQ_LOAD_INP: begin
                push_item(MODE_INPUT, 8'($urandom), 1'($urandom), 16'(addr), 16'(qty));
                return;
            end
            RQ_MODE3: begin
                push_item(MODE_NONE, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
                return;
            end
            default: ;
        endcase
        proto = (kind == RQ_PROTO) ? 16'($urandom_range(1, 65535)) : PROTO_ID;
        f = {8'($urandom), 8'($urandom), proto[15:8], proto[7:0], 8'h00, 8'h06,
             8'($urandom), fc, 8'(addr >> 8), 8'(addr), 8'(qty >> 8), 8'(qty)};
        if (kind == RQ_WRN || kind == RQ_WRN_BADBC || kind == RQ_WRN_SHORT) begin
            n = (kind == RQ_WRN_BADBC) ? 2 * qty + 1 + $urandom_range(0, 1) * 2 : 2 * qty;
            f = {f, 8'(n)};
            if (kind == RQ_WRN_SHORT) n = $urandom_range(0, n > 0 ? n - 1 : 0);
            repeat (n) f = {f, 8'($urandom)};
        end else if (kind == RQ_SHORT_FRAME) begin
            f = f[0:$urandom_range(0, 6)];
        end else if (kind == RQ_SHORT_PDU) begin
            f = f[0:$urandom_range(7, 10)];
        end else if (kind == RQ_OVERFLOW) begin
            repeat (FCAP + 20 - f.size()) f = {f, 8'($urandom)};
        end
        f[5] = 8'(f.size() - 6);
        push_frame(f, tag);
    endfunction

    localparam int N_DIR = 21;
    t_dir_row dir_rows [N_DIR] = '{
        '{RQ_WRN,        FC_WRITE_MULTI, 0,      4,    0, 8'h00},
        '{RQ_READ,       FC_READ_HOLD,   0,      1,    0, 8'h00},
        '{RQ_LOAD_COIL,  8'h00,          0,      1,    0, 8'h00},
        '{RQ_LOAD_COIL,  8'h00,          2047,   1,    0, 8'h00},
        '{RQ_LOAD_COIL,  8'h00,          65535,  1,    0, 8'h00},
        '{RQ_LOAD_INP,   8'h00,          1023,   65535, 0, 8'h00},
        '{RQ_LOAD_INP,   8'h00,          1024,   4660, 0, 8'h00},
        '{RQ_MODE3,      8'h00,          0,      0,    0, 8'h00},
        '{RQ_READ,       FC_READ_COILS,  48,     2000, 0, 8'h00},
        '{RQ_READ,       FC_READ_COILS,  0,      2001, 1, EXC_VALUE},
        '{RQ_READ,       FC_READ_COILS,  2047,   2,    1, EXC_ADDR},
        '{RQ_READ,       FC_READ_INPUT,  899,    125,  0, 8'h00},
        '{RQ_READ,       FC_READ_INPUT,  900,    125,  1, EXC_ADDR},
        '{RQ_READ,       FC_READ_HOLD,   0,      0,    1, EXC_VALUE},
        '{RQ_WR1,        FC_WRITE_ONE,   1023,   65535, 0, 8'h00},
        '{RQ_WR1,        FC_WRITE_ONE,   1024,   1,    1, EXC_ADDR},
        '{RQ_WRN,        FC_WRITE_MULTI, 1020,   4,    0, 8'h00},
        '{RQ_WRN_BADBC,  FC_WRITE_MULTI, 0,      3,    1, EXC_VALUE},
        '{RQ_SHORT_PDU,  FC_WRITE_ONE,   0,      0,    1, EXC_VALUE},
        '{RQ_SHORT_FRAME, FC_READ_HOLD,  0,      1,    0, 8'h00},
        '{RQ_PROTO,      FC_READ_HOLD,   0,      1,    0, 8'h00}
    };

    function automatic int pick_addr(int span);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1, 2:    return span - $urandom_range(1, 12);
            default: return $urandom_range(0, 31);
        endcase
    endfunction

    function automatic void queue_random();
        t_frame_tag tag;
        int r;
        tag = '{0, 8'h00, 8'h00};
        r = $urandom_range(0, 99);
        if (r < 14)
            queue_request(RQ_READ, FC_READ_COILS, pick_addr(NCOIL),
                          ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2001)
                                                       : $urandom_range(0, 40), tag);
        else if (r < 28)
            queue_request(RQ_READ, $urandom_range(0, 1) ? FC_READ_HOLD : FC_READ_INPUT,
                          pick_addr(NHOLD), ($urandom_range(0, 9) == 0) ?
                          $urandom_range(1, 126) : $urandom_range(0, 8), tag);
        else if (r < 40)
            queue_request(RQ_WR1, FC_WRITE_ONE, pick_addr(NHOLD), $urandom_range(0, 65535), tag);
        else if (r < 52)
            queue_request(RQ_WRN, FC_WRITE_MULTI, pick_addr(NHOLD),
                          ($urandom_range(0, 15) == 0) ? $urandom_range(0, 124)
                                                       : $urandom_range(0, 6), tag);
        else if (r < 62)
            queue_request(RQ_LOAD_COIL, 8'h00, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 63),
                          $urandom_range(0, 65535), tag);
        else if (r < 72)
            queue_request(RQ_LOAD_INP, 8'h00, ($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 31),
                          $urandom_range(0, 65535), tag);
        else if (r < 76) queue_request(RQ_MODE3, 8'h00, 0, 0, tag);
        else if (r < 80) queue_request(RQ_SHORT_FRAME, 8'($urandom), 0, 0, tag);
        else if (r < 84) queue_request(RQ_PROTO, FC_READ_HOLD, 0, 1, tag);
        else if (r < 88) queue_request(RQ_SHORT_PDU, 8'($urandom), 0, 1, tag);
        else if (r < 94)
            queue_request($urandom_range(0, 1) ? RQ_WRN_BADBC : RQ_WRN_SHORT, FC_WRITE_MULTI,
                          $urandom_range(0, 40), $urandom_range(1, 8), tag);
        else
            queue_request(RQ_READ, 8'($urandom), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), tag);
    endfunction

    function automatic void set_idling(int phase);
        src_idle = (phase == 0) ? 19 : (phase == 1) ? 60 : 0;
        snk_idle = (phase == 0) ? 60 : (phase == 1) ? 19 : 0;
    endfunction

    initial begin
        int phase;
        t_frame_tag tag;
        flen = 0;
        foreach (coil_bits[i]) coil_bits[i] = 1'b0;
        foreach (hold_words[i]) hold_words[i] = '0;
        foreach (inp_words[i]) inp_words[i] = '0;
        foreach (fbuf[i]) fbuf[i] = '0;
        set_idling(0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            tag = '{dir_rows[i].typed, dir_rows[i].fc, dir_rows[i].typed_code};
            queue_request(dir_rows[i].kind, dir_rows[i].fc, dir_rows[i].addr,
                          dir_rows[i].qty, tag);
        end
        phase = 0;
        while (n_queued < 420) begin
            queue_random();
            if (phase < 2 && n_queued >= 250 + 85 * phase) begin
                while (request_q.size() != 0) @(posedge i_clk);
                phase++;
                set_idling(phase);
                if (phase == 2) hold_left = 600;
            end
        end
        while (request_q.size() != 0 || in_valid || resp_words_q.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d request items: %0d served frames, %0d dropped, %0d exceptions",
                 n_queued, n_frames, n_dropped, n_exc);
        $display("%0d response words checked, mismatches: %0d", n_words, n_errors);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #40ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
